### design/ili_pkg.sv
// ----------------------------------------------------------------------------
// ili_pkg
// Shared types and constants of the interval list intersection block.
// ----------------------------------------------------------------------------
package ili_pkg;

    // Capacity of each interval list.
    localparam int LIST_DEPTH = 32;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int VAL_W      = 32;

    // Command codes carried in the cmd field.
    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_RUN    = 2'd2
    } t_cmd;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

    // Input item.
    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [VAL_W-1:0] start_value;
        logic signed [VAL_W-1:0] end_value;
    } t_in;

    // Result item.
    typedef struct packed {
        logic signed [VAL_W-1:0] out_start;
        logic signed [VAL_W-1:0] out_end;
        logic                    no_overlap;
        logic                    dropped;
        logic                    last_result;
    } t_out;

    // One stored interval.
    typedef struct packed {
        logic signed [VAL_W-1:0] start_v;
        logic signed [VAL_W-1:0] end_v;
    } t_entry;

endpackage

### design/ili_list_ram.sv
// ----------------------------------------------------------------------------
// ili_list_ram
// Interval store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ili_list_ram (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [ili_pkg::IDX_W-1:0] i_waddr,
    input  ili_pkg::t_entry          i_wdata,
    input  logic [ili_pkg::IDX_W-1:0] i_raddr,
    output ili_pkg::t_entry          o_rdata
);

    ili_pkg::t_entry r_mem [ili_pkg::LIST_DEPTH];
    ili_pkg::t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/ili_result_reg.sv
// ----------------------------------------------------------------------------
// ili_result_reg
// Output register that holds one result until its transfer completes.
// ----------------------------------------------------------------------------
module ili_result_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ili_pkg::t_out i_push_data,
    output logic          o_free,
    output logic          o_valid,
    input  logic          i_ready,
    output ili_pkg::t_out o_data
);

    logic          r_valid;
    ili_pkg::t_out r_data;

    // The slot is free when empty or when its result leaves this cycle.
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_push_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // A result is only loaded when the slot can take it.
    a_push_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_free)
        else $error("result pushed into an occupied output register");

endmodule

### design/interval_list_intersection.sv
// ----------------------------------------------------------------------------
// interval_list_intersection
// Loads intervals into two list memories and, on a run, walks both lists to
// emit every nonempty intersection in order.
// ----------------------------------------------------------------------------
//   Channel   Ports                        Moves
//   input     i_valid / o_ready / i_data   load A, load B or run command
//   output    o_valid / i_ready / o_data   intersection results of a run
//
// A run starts from idle, takes one walk step per cycle while the walk is not
// stalled (count A + count B - 1 steps at most) and closes in the finish state,
// where the last result, or a no-overlap marker when none was found, is pushed.
// Input is taken only between runs; a full output register stalls the walk when a held result must leave.
// Reset clears the list counts and the overflow flag; memory contents are
// not cleared.
module interval_list_intersection (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  ili_pkg::t_in i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output ili_pkg::t_out o_data
);

    ili_pkg::t_state           r_state, n_state;
    logic [ili_pkg::CNT_W-1:0] r_cnt_a, n_cnt_a;
    logic [ili_pkg::CNT_W-1:0] r_cnt_b, n_cnt_b;
    logic [ili_pkg::CNT_W-1:0] r_i, n_i;
    logic [ili_pkg::CNT_W-1:0] r_j, n_j;
    logic                      r_ovf, n_ovf;
    logic                      r_pend_valid, n_pend_valid;
    ili_pkg::t_entry           r_pend, n_pend;

    logic            we_a, we_b;
    ili_pkg::t_entry wdata;
    ili_pkg::t_entry rd_a, rd_b;
    ili_pkg::t_entry cand;
    logic            cand_ok;
    logic            adv_a;
    logic            push;
    ili_pkg::t_out   push_data;
    logic            out_free;

    assign wdata = '{start_v: i_data.start_value, end_v: i_data.end_value};

    // List memories; the read address follows the next walk indices.
    ili_list_ram u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[ili_pkg::IDX_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (n_i[ili_pkg::IDX_W-1:0]),
        .o_rdata (rd_a)
    );

    ili_list_ram u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[ili_pkg::IDX_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (n_j[ili_pkg::IDX_W-1:0]),
        .o_rdata (rd_b)
    );

    ili_result_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_free      (out_free),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

    // Intersection of the two current intervals and the advance decision.
    always_comb begin
        cand.start_v = (rd_a.start_v > rd_b.start_v) ? rd_a.start_v : rd_b.start_v;
        cand.end_v   = (rd_a.end_v < rd_b.end_v) ? rd_a.end_v : rd_b.end_v;
        cand_ok      = (cand.start_v <= cand.end_v);
        adv_a        = (rd_a.end_v < rd_b.end_v);
    end

    // State register and walk registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ili_pkg::ST_IDLE;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_ovf        <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_a      <= n_cnt_a;
            r_cnt_b      <= n_cnt_b;
            r_i          <= n_i;
            r_j          <= n_j;
            r_ovf        <= n_ovf;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    // Next state, loads, walk steps and result pushes. The newest result is
    // held back until the next one is found, so that the final one can be marked last.
    always_comb begin
        n_state      = r_state;
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_i          = r_i;
        n_j          = r_j;
        n_ovf        = r_ovf;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        we_a         = 1'b0;
        we_b         = 1'b0;
        push         = 1'b0;
        push_data    = '0;
        o_ready      = 1'b0;

        case (r_state)
            ili_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                n_i     = '0;
                n_j     = '0;
                if (i_valid) begin
                    case (i_data.cmd)
                        ili_pkg::CMD_LOAD_A: begin
                            if (r_cnt_a < ili_pkg::CNT_W'(ili_pkg::LIST_DEPTH)) begin
                                we_a    = 1'b1;
                                n_cnt_a = r_cnt_a + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        ili_pkg::CMD_LOAD_B: begin
                            if (r_cnt_b < ili_pkg::CNT_W'(ili_pkg::LIST_DEPTH)) begin
                                we_b    = 1'b1;
                                n_cnt_b = r_cnt_b + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        ili_pkg::CMD_RUN: begin
                            if (r_cnt_a == '0 || r_cnt_b == '0) begin
                                n_state = ili_pkg::ST_FINISH;
                            end else begin
                                n_state = ili_pkg::ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ili_pkg::ST_WALK: begin
                // Stall only when a held result must leave and the slot is busy.
                if (!(cand_ok && r_pend_valid) || out_free) begin
                    if (cand_ok) begin
                        push         = r_pend_valid;
                        push_data    = '{out_start: r_pend.start_v, out_end: r_pend.end_v,
                                         no_overlap: 1'b0, dropped: r_ovf,
                                         last_result: 1'b0};
                        n_pend       = cand;
                        n_pend_valid = 1'b1;
                    end
                    if (adv_a) begin
                        n_i = r_i + 1'b1;
                        if (n_i == r_cnt_a) begin
                            n_state = ili_pkg::ST_FINISH;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                        if (n_j == r_cnt_b) begin
                            n_state = ili_pkg::ST_FINISH;
                        end
                    end
                end
            end

            ili_pkg::ST_FINISH: begin
                if (out_free) begin
                    push = 1'b1;
                    if (r_pend_valid) begin
                        push_data = '{out_start: r_pend.start_v, out_end: r_pend.end_v,
                                      no_overlap: 1'b0, dropped: r_ovf,
                                      last_result: 1'b1};
                    end else begin
                        push_data = '{out_start: '0, out_end: '0, no_overlap: 1'b1,
                                      dropped: r_ovf, last_result: 1'b1};
                    end
                    n_cnt_a      = '0;
                    n_cnt_b      = '0;
                    n_ovf        = 1'b0;
                    n_pend_valid = 1'b0;
                    n_state      = ili_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = ili_pkg::ST_IDLE;
            end
        endcase
    end

    // List counts never pass the capacity.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt_a <= ili_pkg::CNT_W'(ili_pkg::LIST_DEPTH)
        && r_cnt_b <= ili_pkg::CNT_W'(ili_pkg::LIST_DEPTH))
        else $error("list count above capacity");

    // The walk only reads entries that were loaded.
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ili_pkg::ST_WALK |-> (r_i < r_cnt_a && r_j < r_cnt_b))
        else $error("walk index beyond loaded entries");

    // Closing a run clears both lists and the overflow flag.
    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ili_pkg::ST_FINISH && out_free)
        |=> (r_cnt_a == '0 && r_cnt_b == '0 && !r_ovf && !r_pend_valid))
        else $error("run did not clear list state");

endmodule
